### rtl/mte_pkg.sv
// shared types and character codes for the markup text escaper
// no dependencies
`default_nettype none

package mte_pkg;

  localparam int unsigned SEQ_MAX = 6;
  localparam int unsigned LEN_W   = 3;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // one escaped sequence: bytes in order from index 0, len of zero means nothing to send
  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;
    logic [LEN_W-1:0]        len;
  } seq_t;

endpackage

`default_nettype wire

### rtl/markup_text_escaper.sv
// markup text escaper: turns text bytes into entity-escaped output bytes
// depends on mte_pkg, mte_classify, mte_emitter
//
// usage
// - text channel: text_valid / text_stall carry one text_byte per beat
// - escaped channel: escaped_valid / escaped_stall carry out_byte and
//   last_of_run, one output byte per beat; last_of_run marks the final
//   byte of the run that one text byte produced (one to six bytes)
// - a zero text byte is the string terminator: taken, produces no beats
// - cfg_we writes cfg_data into attribute_mode (0 element text, 1 attribute
//   value); write it only while nothing is in flight
// - the first output byte passes the input register and then the result
//   register before it is offered on the escaped channel
// - throughput: one text byte per cycle while each maps to one output byte
//   and the output does not stall; a byte expanding to n output bytes holds
//   the single result register until all n are taken, which sets the rate
// - the input register keeps taking one more byte while the output stalls
// - reset (rst, synchronous) empties both stages and selects text mode
`default_nettype none

module markup_text_escaper (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data,
  input  wire logic       text_valid,
  output logic            text_stall,
  input  wire logic [7:0] text_byte,
  output logic            escaped_valid,
  input  wire logic       escaped_stall,
  output logic      [7:0] out_byte,
  output logic            last_of_run
);

  // escaping mode register
  logic attribute_mode;

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  mte_pkg::seq_t seq;
  logic          can_load;
  logic          load;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_mode <= 1'b0;
    end else if (cfg_we) begin
      attribute_mode <= cfg_data;
    end
  end

  // held byte moves on when the result stage frees up this cycle
  assign load       = in_full && can_load;
  assign text_stall = in_full && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (text_valid && !text_stall) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      in_byte <= text_byte;
    end
  end

  // escape lookup between input and result registers
  mte_classify u_classify (
    .text_byte      (in_byte),
    .attribute_mode (attribute_mode),
    .seq            (seq)
  );

  // result register and byte sequencer
  mte_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .seq_in        (seq),
    .can_load      (can_load),
    .escaped_valid (escaped_valid),
    .escaped_stall (escaped_stall),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

### rtl/mte_classify.sv
// maps one text byte and the escaping mode to its output sequence
// depends on mte_pkg
`default_nettype none

module mte_classify (
  input  wire logic        [7:0] text_byte,
  input  wire logic              attribute_mode,
  output mte_pkg::seq_t          seq
);

  logic       ctrl_escape;
  logic [7:0] tens;
  logic [7:0] ones;

  // decimal split of a control byte, value below 32
  always_comb begin
    if (text_byte >= 8'd30) begin
      tens = 8'd3;
      ones = text_byte - 8'd30;
    end else if (text_byte >= 8'd20) begin
      tens = 8'd2;
      ones = text_byte - 8'd20;
    end else if (text_byte >= 8'd10) begin
      tens = 8'd1;
      ones = text_byte - 8'd10;
    end else begin
      tens = 8'd0;
      ones = text_byte;
    end
  end

  assign ctrl_escape = (text_byte < mte_pkg::CH_SPACE) && (text_byte != mte_pkg::CH_TAB) &&
                       (((text_byte != mte_pkg::CH_LF) && (text_byte != mte_pkg::CH_CR)) ||
                        attribute_mode);

  always_comb begin
    seq.bytes    = '0;
    seq.len      = mte_pkg::LEN_W'(1);
    seq.bytes[0] = text_byte;
    if (text_byte == mte_pkg::CH_NUL) begin
      // terminator: nothing to send
      seq.len = '0;
    end else if (text_byte == mte_pkg::CH_AMP) begin
      seq.bytes[0] = mte_pkg::CH_AMP;
      seq.bytes[1] = mte_pkg::CH_A;
      seq.bytes[2] = mte_pkg::CH_M;
      seq.bytes[3] = mte_pkg::CH_P;
      seq.bytes[4] = mte_pkg::CH_SEMI;
      seq.len      = mte_pkg::LEN_W'(5);
    end else if (text_byte == mte_pkg::CH_LT || text_byte == mte_pkg::CH_GT) begin
      seq.bytes[0] = mte_pkg::CH_AMP;
      seq.bytes[1] = (text_byte == mte_pkg::CH_LT) ? mte_pkg::CH_L : mte_pkg::CH_G;
      seq.bytes[2] = mte_pkg::CH_T;
      seq.bytes[3] = mte_pkg::CH_SEMI;
      seq.len      = mte_pkg::LEN_W'(4);
    end else if (text_byte == mte_pkg::CH_QUOT && attribute_mode) begin
      seq.bytes[0] = mte_pkg::CH_AMP;
      seq.bytes[1] = mte_pkg::CH_Q;
      seq.bytes[2] = mte_pkg::CH_U;
      seq.bytes[3] = mte_pkg::CH_O;
      seq.bytes[4] = mte_pkg::CH_T;
      seq.bytes[5] = mte_pkg::CH_SEMI;
      seq.len      = mte_pkg::LEN_W'(6);
    end else if (ctrl_escape) begin
      seq.bytes[0] = mte_pkg::CH_AMP;
      seq.bytes[1] = mte_pkg::CH_HASH;
      seq.bytes[2] = mte_pkg::CH_ZERO + tens;
      seq.bytes[3] = mte_pkg::CH_ZERO + ones;
      seq.bytes[4] = mte_pkg::CH_SEMI;
      seq.len      = mte_pkg::LEN_W'(5);
    end
  end

endmodule

`default_nettype wire

### rtl/mte_emitter.sv
// result register holding one escaped sequence, sent one byte per beat
// depends on mte_pkg
`default_nettype none

module mte_emitter (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire mte_pkg::seq_t       seq_in,
  output logic                     can_load,
  output logic                     escaped_valid,
  input  wire logic                escaped_stall,
  output logic               [7:0] out_byte,
  output logic                     last_of_run
);

  mte_pkg::seq_t                  seq;
  logic [mte_pkg::LEN_W-1:0]      idx;
  logic                           busy;
  logic                           beat;

  assign escaped_valid = busy;
  assign out_byte      = seq.bytes[idx];
  assign last_of_run   = (idx == seq.len - mte_pkg::LEN_W'(1));
  assign beat          = busy && !escaped_stall;
  assign can_load      = !busy || (beat && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      // zero length sequence leaves the stage empty
      busy <= (seq_in.len != '0);
      idx  <= '0;
    end else if (beat && last_of_run) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (beat) begin
      idx <= idx + mte_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seq <= seq_in;
    end
  end

`ifndef SYNTH
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> (seq.len != '0))
    else $error("busy with empty sequence");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < seq.len))
    else $error("byte index past sequence end");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (beat && !last_of_run) |=> (idx == $past(idx) + mte_pkg::LEN_W'(1)))
    else $error("byte index did not advance");

  a_fresh_after_last: assert property (@(posedge clk) disable iff (rst)
    (beat && last_of_run) |=> (idx == '0))
    else $error("new sequence does not start at first byte");
`endif

endmodule

`default_nettype wire
